// ===== rtl/wrms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wrms_pkg
// Shared constants and types for the windowed RMS meter.
// ---------------------------------------------------------------------------
package wrms_pkg;

  // Parameter defaults
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF  = 16;

  // Fixed field widths
  localparam int CFG_BITS      = 16;
  localparam int RMS_BITS      = 16;
  localparam int OUT_TDATA_BITS = 3 * RMS_BITS;
  localparam int SUM_BITS      = 40;

  // Millivolt scaling: mv = floor(raw * 3300 / (2^SAMPLE_BITS - 1))
  localparam int MV_FULL_SCALE  = 3300;
  localparam int MV_SCALE_BITS  = 12;  // bits of the 3300 multiplier
  localparam int MV_BITS        = 12;  // mv never exceeds 3300

  localparam int WINDOW_RESET = 2400;

  // Q.4 result: the mean is taken of sum * 2^8 before the square root
  localparam int Q4_SHIFT       = 8;
  localparam int DIVIDEND_BITS  = SUM_BITS + Q4_SHIFT;
  localparam int ROOT_BITS      = DIVIDEND_BITS / 2;
  localparam int SQREM_BITS     = ROOT_BITS + 3;
  localparam int DIV_STEPS      = DIVIDEND_BITS;
  localparam int SQRT_STEPS     = ROOT_BITS;
  localparam int STEP_BITS      = 6;

  // Snapshot queue between accumulator and root unit
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = 1;
  localparam int QUEUE_CNT_BITS = 2;

  // Root unit sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_DONE
  } bk_state_t;

  // Commands from the sequencer to each divide/root lane
  typedef struct packed {
    logic load;
    logic div_step;
    logic sqrt_step;
  } lane_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/wrms_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wrms_front
// Sample pipeline: millivolt scaling, squaring and window accumulation.
// Pushes one snapshot (sums and count) into the queue per finished window.
// ---------------------------------------------------------------------------
module wrms_front #(
  parameter int SAMPLE_BITS = wrms_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = wrms_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        cfg_wr_en,
  input  wire logic [wrms_pkg::CFG_BITS-1:0]               cfg_wr_data,
  input  wire logic                                        in_valid,
  output      logic                                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0]                      in_sample,
  input  wire logic                                        q_full,
  output      logic                                        q_push,
  output      logic [2*wrms_pkg::SUM_BITS+COUNT_BITS-1:0]  q_data
);

  localparam int PROD_BITS = SAMPLE_BITS + wrms_pkg::MV_SCALE_BITS;
  localparam int RSQ_BITS  = 2 * SAMPLE_BITS;
  localparam int MSQ_BITS  = 2 * wrms_pkg::MV_BITS;
  localparam int QUO_BITS  = wrms_pkg::MV_SCALE_BITS + 1;
  localparam int FOLD_BITS = ((SAMPLE_BITS > wrms_pkg::MV_SCALE_BITS) ?
                              SAMPLE_BITS : wrms_pkg::MV_SCALE_BITS) + 1;
  localparam int CMP_BITS  = (COUNT_BITS > wrms_pkg::CFG_BITS) ?
                             COUNT_BITS : wrms_pkg::CFG_BITS;
  localparam int SUM_BITS  = wrms_pkg::SUM_BITS;
  localparam logic [SAMPLE_BITS-1:0] FULL_CODE = '1;

  // pipeline registers
  logic                         s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [SAMPLE_BITS-1:0]       s1_raw_r;
  logic [PROD_BITS-1:0]         s2_prod_r;
  logic [RSQ_BITS-1:0]          s2_rsq_r, s3_rsq_r, s4_rsq_r;
  logic [wrms_pkg::MV_BITS-1:0] s3_mv_r;
  logic [MSQ_BITS-1:0]          s4_msq_r;

  // accumulator state
  logic [wrms_pkg::CFG_BITS-1:0] win_len_r;
  logic [COUNT_BITS-1:0]         count_r;
  logic [SUM_BITS-1:0]           rsum_r, msum_r;

  logic                          adv;
  logic                          take;
  logic                          win_end;
  logic [COUNT_BITS-1:0]         count_inc, n_rep;
  logic [SUM_BITS-1:0]           rsum_add, msum_add;

  // divide by 2^k - 1 by folding the high part back onto the low part
  logic [QUO_BITS-1:0]           q0, q1, q2;
  logic [FOLD_BITS-1:0]          r0, r1, r2;
  logic [wrms_pkg::MV_BITS-1:0]  mv_c;

  always_comb begin
    q0   = QUO_BITS'(s2_prod_r >> SAMPLE_BITS);
    r0   = FOLD_BITS'(s2_prod_r[SAMPLE_BITS-1:0]) + FOLD_BITS'(q0);
    q1   = q0 + QUO_BITS'(r0 >> SAMPLE_BITS);
    r1   = FOLD_BITS'(r0[SAMPLE_BITS-1:0]) + (r0 >> SAMPLE_BITS);
    q2   = q1 + QUO_BITS'(r1 >> SAMPLE_BITS);
    r2   = FOLD_BITS'(r1[SAMPLE_BITS-1:0]) + (r1 >> SAMPLE_BITS);
    mv_c = wrms_pkg::MV_BITS'(q2 + QUO_BITS'(r2 >= FOLD_BITS'(FULL_CODE)));
  end

  // whole pipeline holds while the last stage waits on a full queue
  assign adv      = !(s4_v_r && q_full);
  assign in_ready = adv;
  assign take     = s4_v_r && adv;

  // window bookkeeping
  always_comb begin
    count_inc = count_r + COUNT_BITS'(1);
    win_end   = CMP_BITS'(count_inc) >= CMP_BITS'(win_len_r);
    n_rep     = (count_inc == '0) ? COUNT_BITS'(1) : count_inc;
    rsum_add  = rsum_r + SUM_BITS'(s4_rsq_r);
    msum_add  = msum_r + SUM_BITS'(s4_msq_r);
  end

  assign q_push = take && win_end;
  assign q_data = {n_rep, msum_add, rsum_add};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // data path: multiplies in stages 2 and 4, registered
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_raw_r  <= in_sample;
      s2_prod_r <= PROD_BITS'(s1_raw_r) * PROD_BITS'(wrms_pkg::MV_FULL_SCALE);
      s2_rsq_r  <= RSQ_BITS'(s1_raw_r) * RSQ_BITS'(s1_raw_r);
      s3_mv_r   <= mv_c;
      s3_rsq_r  <= s2_rsq_r;
      s4_msq_r  <= MSQ_BITS'(s3_mv_r) * MSQ_BITS'(s3_mv_r);
      s4_rsq_r  <= s3_rsq_r;
    end
  end

  // window length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= wrms_pkg::CFG_BITS'(wrms_pkg::WINDOW_RESET);
    end else if (cfg_wr_en) begin
      win_len_r <= cfg_wr_data;
    end
  end

  // accumulators, cleared when a window is handed on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rsum_r  <= '0;
      msum_r  <= '0;
    end else if (take) begin
      if (win_end) begin
        count_r <= '0;
        rsum_r  <= '0;
        msum_r  <= '0;
      end else begin
        count_r <= count_inc;
        rsum_r  <= rsum_add;
        msum_r  <= msum_add;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wrms_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wrms_fifo
// Short snapshot queue between the accumulator and the root unit.
// ---------------------------------------------------------------------------
module wrms_fifo #(
  parameter int WIDTH = 2 * wrms_pkg::SUM_BITS + wrms_pkg::COUNT_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] pop_data,
  output      logic             full,
  output      logic             empty
);

  localparam int PB = wrms_pkg::QUEUE_PTR_BITS;
  localparam int CB = wrms_pkg::QUEUE_CNT_BITS;

  logic [WIDTH-1:0] slot_r [wrms_pkg::QUEUE_DEPTH];
  logic [PB-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CB-1:0]    fill_r;

  function automatic logic [PB-1:0] ptr_inc(input logic [PB-1:0] p);
    ptr_inc = (p == PB'(wrms_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PB'(1);
  endfunction

  assign full     = (fill_r == CB'(wrms_pkg::QUEUE_DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      fill_r <= fill_r + CB'(1);
      else if (pop && !push) fill_r <= fill_r - CB'(1);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wrms_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wrms_lane
// One RMS lane: restoring divide of sum*256 by n, one bit a cycle, then a
// digit-by-digit square root, one result bit a cycle, in the same register.
// ---------------------------------------------------------------------------
module wrms_lane #(
  parameter int COUNT_BITS = wrms_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire wrms_pkg::lane_ctl_t             ctl,
  input  wire logic [wrms_pkg::SUM_BITS-1:0]   sum_in,
  input  wire logic [COUNT_BITS-1:0]           n_in,
  output      logic [wrms_pkg::RMS_BITS-1:0]   rms
);

  localparam int DW = wrms_pkg::DIVIDEND_BITS;
  localparam int RW = wrms_pkg::ROOT_BITS;
  localparam int SW = wrms_pkg::SQREM_BITS;

  logic [DW-1:0]         acc_r, acc_nxt;
  logic [COUNT_BITS-1:0] drem_r, drem_nxt;
  logic [SW-1:0]         srem_r, srem_nxt;
  logic [RW-1:0]         root_r, root_nxt;
  logic [COUNT_BITS:0]   dshift;
  logic [SW-1:0]         sshift, trial;

  always_comb begin
    dshift   = {drem_r, acc_r[DW-1]};
    sshift   = {srem_r[SW-3:0], acc_r[DW-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    acc_nxt  = acc_r;
    drem_nxt = drem_r;
    srem_nxt = srem_r;
    root_nxt = root_r;
    if (ctl.load) begin
      acc_nxt  = {sum_in, {wrms_pkg::Q4_SHIFT{1'b0}}};
      drem_nxt = '0;
      srem_nxt = '0;
      root_nxt = '0;
    end else if (ctl.div_step) begin
      // quotient bits shift in from the bottom as dividend bits leave the top
      if (dshift >= {1'b0, n_in}) begin
        drem_nxt = COUNT_BITS'(dshift - {1'b0, n_in});
        acc_nxt  = {acc_r[DW-2:0], 1'b1};
      end else begin
        drem_nxt = dshift[COUNT_BITS-1:0];
        acc_nxt  = {acc_r[DW-2:0], 1'b0};
      end
    end else if (ctl.sqrt_step) begin
      // two radicand bits per step, one root bit
      acc_nxt = {acc_r[DW-3:0], 2'b00};
      if (sshift >= trial) begin
        srem_nxt = sshift - trial;
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        srem_nxt = sshift;
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    drem_r <= drem_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
  end

  assign rms = root_r[wrms_pkg::RMS_BITS-1:0];

endmodule
`default_nettype wire

// ===== rtl/wrms_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wrms_back
// Root unit: pops a window snapshot, runs both lanes through divide and
// square root, and holds the finished result in the output register.
// ---------------------------------------------------------------------------
module wrms_back #(
  parameter int COUNT_BITS = wrms_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        q_empty,
  output      logic                                        q_pop,
  input  wire logic [2*wrms_pkg::SUM_BITS+COUNT_BITS-1:0]  q_data,
  output      logic                                        out_valid,
  input  wire logic                                        out_ready,
  output      logic [wrms_pkg::RMS_BITS-1:0]               out_rms_raw,
  output      logic [wrms_pkg::RMS_BITS-1:0]               out_rms_mv,
  output      logic [wrms_pkg::RMS_BITS-1:0]               out_count
);

  localparam int SB = wrms_pkg::SUM_BITS;
  localparam int TB = wrms_pkg::STEP_BITS;

  wrms_pkg::bk_state_t   state_r, state_nxt;
  wrms_pkg::lane_ctl_t   ctl;
  logic [TB-1:0]         step_r, step_nxt;
  logic [COUNT_BITS-1:0] n_r;
  logic                  load_out;
  logic                  out_valid_r;
  logic [wrms_pkg::RMS_BITS-1:0] rms_raw_c, rms_mv_c;
  logic [wrms_pkg::RMS_BITS-1:0] rms_raw_r, rms_mv_r, count_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ctl       = '0;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      wrms_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ctl.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = wrms_pkg::BK_DIV;
        end
      end
      wrms_pkg::BK_DIV: begin
        ctl.div_step = 1'b1;
        if (step_r == TB'(wrms_pkg::DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = wrms_pkg::BK_SQRT;
        end else begin
          step_nxt = step_r + TB'(1);
        end
      end
      wrms_pkg::BK_SQRT: begin
        ctl.sqrt_step = 1'b1;
        if (step_r == TB'(wrms_pkg::SQRT_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = wrms_pkg::BK_DONE;
        end else begin
          step_nxt = step_r + TB'(1);
        end
      end
      wrms_pkg::BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = wrms_pkg::BK_IDLE;
        end
      end
      default: state_nxt = wrms_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wrms_pkg::BK_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // window length of the snapshot in flight
  always_ff @(posedge clk) begin
    if (q_pop) begin
      n_r <= q_data[2*SB +: COUNT_BITS];
    end
  end

  // raw and millivolt lanes run side by side
  wrms_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_raw (
    .clk    (clk),
    .ctl    (ctl),
    .sum_in (q_data[0 +: SB]),
    .n_in   (n_r),
    .rms    (rms_raw_c)
  );

  wrms_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_mv (
    .clk    (clk),
    .ctl    (ctl),
    .sum_in (q_data[SB +: SB]),
    .n_in   (n_r),
    .rms    (rms_mv_c)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rms_raw_r <= rms_raw_c;
      rms_mv_r  <= rms_mv_c;
      count_r   <= wrms_pkg::RMS_BITS'(n_r);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_rms_raw = rms_raw_r;
  assign out_rms_mv  = rms_mv_r;
  assign out_count   = count_r;

endmodule
`default_nettype wire

// ===== rtl/windowed_rms_meter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// windowed_rms_meter_unit
// Windowed RMS meter for a stream of converter samples.
// ---------------------------------------------------------------------------
// Each request on the in_ channel carries one unsigned sample. It is scaled
// to millivolts, both values are squared and summed, and when window_len
// samples have been taken one request leaves on the out_ channel with the
// RMS of the raw and of the millivolt values (unsigned Q12.4) and the count.
// window_len is written through cfg_wr_en/cfg_wr_data; the user must write it only while
// the meter is idle, which the block itself does not enforce; zero acts as one.
// Throughput: one sample per cycle. A four-stage front pipeline (capture,
// scale and square, fold divide by full scale, square) and the accumulator
// feed a two-entry snapshot queue. The root unit takes one window at a time:
// it pops a snapshot, runs the bit-serial divide by the count and then the
// square root, both lanes in parallel, and loads the output register. With
// windows shorter than the root unit's time per window the queue fills and
// in_tready drops until the root unit frees a slot.
// When the receiver stalls, the result waits in the output register, the
// root unit holds the next one, then the queue and the front pipeline stall.
// Reset (rst_n low, synchronous) clears the sums, count, queue and valids and
// sets window_len to 2400.
// ---------------------------------------------------------------------------
module windowed_rms_meter_unit #(
  parameter int SAMPLE_BITS = wrms_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = wrms_pkg::COUNT_BITS_DEF,
  parameter int IN_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration: window_len
  input  wire logic                                cfg_wr_en,
  input  wire logic [wrms_pkg::CFG_BITS-1:0]       cfg_wr_data,
  // samples
  input  wire logic                                in_tvalid,
  output      logic                                in_tready,
  input  wire logic [IN_TDATA_BITS-1:0]            in_tdata,   // sample_raw
  // results
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  // rms_raw_q4[15:0], rms_mv_q4[31:16], sample_count[47:32]
  output      logic [wrms_pkg::OUT_TDATA_BITS-1:0] out_tdata
);

  localparam int ENTRY_BITS = 2 * wrms_pkg::SUM_BITS + COUNT_BITS;

  logic                          q_full, q_empty, q_push, q_pop;
  logic [ENTRY_BITS-1:0]         q_wdata, q_rdata;
  logic [wrms_pkg::RMS_BITS-1:0] rms_raw, rms_mv, cnt;

  wrms_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_sample   (in_tdata[SAMPLE_BITS-1:0]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  wrms_fifo #(.WIDTH(ENTRY_BITS)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  wrms_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_data      (q_rdata),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_rms_raw (rms_raw),
    .out_rms_mv  (rms_mv),
    .out_count   (cnt)
  );

  assign out_tdata = {cnt, rms_mv, rms_raw};

endmodule
`default_nettype wire
